>>> hw/rtl/cwia_pkg.sv
// Package for the checked-width integer ALU: opcodes, stage payload types.
// No dependencies; imported by cwia_divider, checked_width_integer_alu, cwia_checker and the testbench.
`default_nettype none
package cwia_pkg;
  typedef enum logic [3:0] {
    OP_ABS = 4'd0, OP_AND = 4'd1, OP_CHV = 4'd2, OP_DIV = 4'd3,
    OP_MAX = 4'd4, OP_MIN = 4'd5, OP_MINUS = 4'd6, OP_MULT = 4'd7,
    OP_NEG = 4'd8, OP_NOT = 4'd9, OP_OR = 4'd10, OP_PLUS = 4'd11,
    OP_REM = 4'd12, OP_SHL = 4'd13, OP_SHR = 4'd14, OP_XOR = 4'd15
  } op_t;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned WIDTH_BITS = 7;

  // Per-beat control carried alongside the divider datapath
  typedef struct packed {
    logic                  ok;
    logic                  wrap;
    logic                  sgn;
    logic [WIDTH_BITS-1:0] sz;
    op_t                   op;
  } ctl_t;
endpackage
`default_nettype wire

>>> hw/rtl/checked_width_integer_alu.sv
// Top level of the checked-width integer ALU.
// Depends on cwia_pkg and cwia_divider.
//
// Usage: present one operation per beat on the in_ channel (valid/ready);
// one result beat (out_folded, out_value) comes back per input, in order.
// Path from input accept to out_valid: decode and 32x32 partial products,
// product sum, a 64-stage bit-per-stage divider that every beat rides
// through, then the range check and output register.
// Throughput: one beat per cycle while the receiver is not stalling; the divider pipeline sets the depth.
// When the receiver stalls, the whole pipeline holds in place; in_ready
// stays high while the output register is empty or being drained.
// Reset (rst_n low, synchronous) clears all valid bits; no beat is in
// flight afterwards. Results not folded carry out_value of zero.
`default_nettype none
module checked_width_integer_alu #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_op,
  input  wire logic        in_wrap_mode,
  input  wire logic        in_is_signed,
  input  wire logic [6:0]  in_width,
  input  wire logic [63:0] in_operand_a,
  input  wire logic [63:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_folded,
  output logic [63:0]      out_value
);
  import cwia_pkg::*;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------- Stage 1: decode, checks, partial products ----------
  op_t  op_c;
  logic a_neg, b_neg, unary, ok_c;
  logic [63:0] ma, mb;
  assign op_c  = op_t'(in_op);
  assign a_neg = in_operand_a[63];
  assign b_neg = in_operand_b[63];
  assign unary = (op_c == OP_ABS) || (op_c == OP_CHV) || (op_c == OP_NEG) ||
                 (op_c == OP_NOT);
  assign ma    = a_neg ? (64'd0 - in_operand_a) : in_operand_a;
  assign mb    = b_neg ? (64'd0 - in_operand_b) : in_operand_b;

  always_comb begin
    ok_c = 1'b1;
    if (!in_is_signed && (a_neg || (!unary && b_neg))) ok_c = 1'b0;
    if (in_width == 7'd0 || {25'd0, in_width} > VALUE_BITS[31:0]) ok_c = 1'b0;
    case (op_c) inside
      OP_AND, OP_OR, OP_XOR: if (a_neg || b_neg) ok_c = 1'b0;
      OP_DIV, OP_REM: if (a_neg || b_neg || in_operand_b == 64'd0) ok_c = 1'b0;
      OP_NOT, OP_SHL, OP_SHR: if (in_is_signed || !in_wrap_mode) ok_c = 1'b0;
      default: ;
    endcase
  end

  logic        s1_vld_r;
  ctl_t        s1_ctl_r;
  logic [63:0] s1_a_r, s1_b_r;
  logic [63:0] s1_p00_r, s1_p01_r, s1_p10_r, s1_p11_r;
  logic        s1_pneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
    if (en) begin
      s1_ctl_r  <= '{ok: ok_c, wrap: in_wrap_mode, sgn: in_is_signed,
                     sz: in_width, op: op_c};
      s1_a_r    <= in_operand_a;
      s1_b_r    <= in_operand_b;
      s1_p00_r  <= 64'(ma[31:0])  * 64'(mb[31:0]);
      s1_p01_r  <= 64'(ma[31:0])  * 64'(mb[63:32]);
      s1_p10_r  <= 64'(ma[63:32]) * 64'(mb[31:0]);
      s1_p11_r  <= 64'(ma[63:32]) * 64'(mb[63:32]);
      s1_pneg_r <= a_neg ^ b_neg;
    end
  end

  // ---------- Stage 2: exact 128-bit result for all but mult/div/rem; product sum ----------
  logic [127:0] prod, sa, sb, c2;
  logic [63:0]  ua, ub;
  assign ua   = s1_a_r;
  assign ub   = s1_b_r;
  assign prod = {64'd0, s1_p00_r} + {32'd0, s1_p01_r, 32'd0} +
                {32'd0, s1_p10_r, 32'd0} + {s1_p11_r, 64'd0};
  assign sa   = {{64{ua[63]}}, ua};
  assign sb   = {{64{ub[63]}}, ub};

  always_comb begin
    case (s1_ctl_r.op)
      OP_ABS:   c2 = ua[63] ? (128'd0 - sa) : sa;
      OP_AND:   c2 = {64'd0, ua & ub};
      OP_OR:    c2 = {64'd0, ua | ub};
      OP_XOR:   c2 = {64'd0, ua ^ ub};
      OP_CHV:   c2 = sa;
      OP_MAX:   c2 = ($signed(ua) >= $signed(ub)) ? sa : sb;
      OP_MIN:   c2 = ($signed(ua) <  $signed(ub)) ? sa : sb;
      OP_MINUS: c2 = sa - sb;
      OP_PLUS:  c2 = sa + sb;
      OP_NEG:   c2 = 128'd0 - sa;
      OP_NOT:   c2 = {64'hFFFF_FFFF_FFFF_FFFF, ~ua};
      OP_SHL:   c2 = {64'd0, (ub[63:6] == 58'd0) ? (ua << ub[5:0]) : 64'd0};
      OP_SHR:   c2 = {64'd0, (ub[63:6] == 58'd0) ? (ua >> ub[5:0]) : 64'd0};
      default:  c2 = 128'd0;
    endcase
  end

  logic         s2_vld_r;
  ctl_t         s2_ctl_r;
  logic [127:0] s2_c_r, s2_prod_r;
  logic         s2_pneg_r;
  logic [63:0]  s2_a_r, s2_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
    if (en) begin
      s2_ctl_r  <= s1_ctl_r;
      s2_c_r    <= c2;
      s2_prod_r <= prod;
      s2_pneg_r <= s1_pneg_r;
      s2_a_r    <= s1_a_r;
      s2_b_r    <= s1_b_r;
    end
  end

  // ---------- Stage 3: apply product sign, feed divider ----------
  logic [127:0] c3;
  always_comb begin
    if (s2_ctl_r.op == OP_MULT) begin
      c3 = s2_pneg_r ? (128'd0 - s2_prod_r) : s2_prod_r;
    end else begin
      c3 = s2_c_r;
    end
  end

  logic         d_vld;
  ctl_t         d_ctl;
  logic [63:0]  d_quot, d_rem;
  logic [127:0] d_side;

  cwia_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_vld_r),
    .in_ctl    (s2_ctl_r),
    .in_num    (s2_a_r),
    .in_den    ((s2_b_r == 64'd0) ? 64'd1 : s2_b_r),
    .in_side   (c3),
    .out_valid (d_vld),
    .out_ctl   (d_ctl),
    .out_quot  (d_quot),
    .out_rem   (d_rem),
    .out_side  (d_side)
  );

  // ---------- Final stage: range check into output register ----------
  logic [127:0] cf;
  logic [63:0]  mask, v, sext_v;
  logic         fold_c;
  logic [63:0]  res_c;
  logic [5:0]   top;

  always_comb begin
    case (d_ctl.op)
      OP_DIV:  cf = {64'd0, d_quot};
      OP_REM:  cf = {64'd0, d_rem};
      default: cf = d_side;
    endcase
    mask   = (d_ctl.sz >= 7'd64) ? 64'hFFFF_FFFF_FFFF_FFFF :
             ((64'd1 << d_ctl.sz[5:0]) - 64'd1);
    top    = d_ctl.sz[5:0] - 6'd1;
    v      = cf[63:0] & mask;
    sext_v = v[top] ? (v | ~mask) : v;
    fold_c = d_ctl.ok;
    res_c  = cf[63:0];
    if (d_ctl.sgn) begin
      if (cf[127:64] != {64{cf[63]}} || sext_v != cf[63:0]) fold_c = 1'b0;
    end else if (cf[127] || cf[127:64] != 64'd0 || cf[63:0] > mask) begin
      if (!d_ctl.wrap) fold_c = 1'b0;
      res_c = cf[63:0] & mask;
    end
    if (!fold_c) res_c = 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld;
    end
    if (en) begin
      out_folded <= fold_c;
      out_value  <= res_c;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/cwia_divider.sv
// Pipelined restoring divider: one quotient bit per stage, 64 stages.
// Depends on cwia_pkg. Stalls with the enable input; carries ctl_t and a side word.
`default_nettype none
module cwia_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire cwia_pkg::ctl_t    in_ctl,
  input  wire logic [63:0]       in_num,
  input  wire logic [63:0]       in_den,
  input  wire logic [127:0]      in_side,
  output logic                   out_valid,
  output cwia_pkg::ctl_t         out_ctl,
  output logic [63:0]            out_quot,
  output logic [63:0]            out_rem,
  output logic [127:0]           out_side
);
  import cwia_pkg::*;
  localparam int unsigned N = WORD_BITS;

  logic         vld_r  [N+1];
  ctl_t         ctl_r  [N+1];
  logic [63:0]  quo_r  [N+1];
  logic [63:0]  rmd_r  [N+1];
  logic [63:0]  den_r  [N+1];
  logic [127:0] side_r [N+1];

  // Stage 0 is the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
    if (en) begin
      ctl_r[0]  <= in_ctl;
      quo_r[0]  <= in_num;
      rmd_r[0]  <= '0;
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
    end
  end

  // Shift in one numerator bit, trial subtract, advance
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [64:0] trial;
    logic [64:0] shifted;
    assign shifted = {rmd_r[i], quo_r[i][63]};
    assign trial   = shifted - {1'b0, den_r[i]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (en) begin
        ctl_r[i+1]  <= ctl_r[i];
        den_r[i+1]  <= den_r[i];
        side_r[i+1] <= side_r[i];
        if (!trial[64]) begin
          rmd_r[i+1] <= trial[63:0];
          quo_r[i+1] <= {quo_r[i][62:0], 1'b1};
        end else begin
          rmd_r[i+1] <= shifted[63:0];
          quo_r[i+1] <= {quo_r[i][62:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_r[N];
  assign out_ctl   = ctl_r[N];
  assign out_quot  = quo_r[N];
  assign out_rem   = rmd_r[N];
  assign out_side  = side_r[N];
endmodule
`default_nettype wire

>>> sim/cwia_checker.sv
// Checker for the checked-width integer ALU: watches both channels,
// predicts each fold result and compares it. Depends on cwia_pkg.
`timescale 1ns / 100ps
module cwia_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [3:0]  in_op,
  input  wire logic        in_wrap_mode,
  input  wire logic        in_is_signed,
  input  wire logic [6:0]  in_width,
  input  wire logic [63:0] in_operand_a,
  input  wire logic [63:0] in_operand_b,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_folded,
  input  wire logic [63:0] out_value,
  output int               fail_count,
  output int               pending_folds
);
  import cwia_pkg::*;

  typedef struct {
    logic        folded;
    logic [63:0] value;
  } fold_t;

  fold_t fold_queue[$];

  // Exact evaluation in 130-bit signed arithmetic, then the range check.
  function automatic fold_t fold_op(op_t op, logic wrap, logic sgn, logic [6:0] sz,
                                    logic [63:0] a, logic [63:0] b);
    fold_t r;
    logic signed [129:0] sa, sb, c, lo_lim, hi_lim;
    logic [63:0] mask;
    logic a_neg, b_neg, unary, ok;
    r.folded = 1'b0;
    r.value = '0;
    a_neg = a[63];
    b_neg = b[63];
    unary = (op == OP_ABS) || (op == OP_CHV) || (op == OP_NEG) || (op == OP_NOT);
    sa = {{66{a[63]}}, a};
    sb = {{66{b[63]}}, b};
    ok = 1'b1;
    c = '0;
    if (!sgn && (a_neg || (!unary && b_neg))) return r;
    if (sz < 1 || sz > 64) return r;
    case (op) inside
      OP_ABS: c = a_neg ? -sa : sa;
      OP_AND, OP_OR, OP_XOR: begin
        if (a_neg || b_neg) ok = 1'b0;
        else c = {66'd0, (op == OP_AND) ? (a & b) : (op == OP_OR) ? (a | b) : (a ^ b)};
      end
      OP_CHV: c = sa;
      OP_DIV, OP_REM: begin
        if (a_neg || b_neg || b == 0) ok = 1'b0;
        else c = {66'd0, (op == OP_DIV) ? a / b : a % b};
      end
      OP_MAX: c = (sa >= sb) ? sa : sb;
      OP_MIN: c = (sa < sb) ? sa : sb;
      OP_MINUS: c = sa - sb;
      OP_PLUS: c = sa + sb;
      OP_MULT: c = sa * sb;
      OP_NEG: c = -sa;
      OP_NOT: begin
        if (sgn || !wrap) ok = 1'b0;
        else c = {66'h3_ffff_ffff_ffff_ffff, ~a};
      end
      default: begin
        // shl, shr
        if (sgn || !wrap) ok = 1'b0;
        else if (b >= 64) c = '0;
        else c = {66'd0, (op == OP_SHL) ? (a << b) : (a >> b)};
      end
    endcase
    if (!ok) return r;
    mask = (sz == 64) ? '1 : ((64'd1 << sz) - 1);
    if (sgn) begin
      lo_lim = -(130'sd1 <<< (sz - 1));
      hi_lim = (130'sd1 <<< (sz - 1)) - 1;
      if (c < lo_lim || c > hi_lim) return r;
      r.value = c[63:0];
    end else begin
      hi_lim = {66'd0, mask};
      if (c < 0 || c > hi_lim) begin
        if (!wrap) return r;
        r.value = c[63:0] & mask;
      end else begin
        r.value = c[63:0];
      end
    end
    r.folded = 1'b1;
    return r;
  endfunction

  assign pending_folds = fold_queue.size();

  initial fail_count = 0;

  // Predict on input beats, compare on output beats.
  always @(posedge clk) begin
    fold_t exp_fold;
    if (rst_n && in_valid && in_ready)
      fold_queue.push_back(fold_op(op_t'(in_op), in_wrap_mode, in_is_signed,
                                   in_width, in_operand_a, in_operand_b));
    if (rst_n && out_valid && out_ready) begin
      if (fold_queue.size() == 0) begin
        $error("result beat with no expected fold");
        fail_count <= fail_count + 1;
      end else begin
        exp_fold = fold_queue.pop_front();
        if (out_folded !== exp_fold.folded) begin
          $error("folded: expected %0d actual %0d", exp_fold.folded, out_folded);
          fail_count <= fail_count + 1;
        end else if (out_value !== exp_fold.value) begin
          $error("value: expected %h actual %h", exp_fold.value, out_value);
          fail_count <= fail_count + 1;
        end
      end
    end
  end
endmodule

>>> sim/checked_width_integer_alu_test.sv
// Testbench top for the checked-width integer ALU: clock, reset, directed
// and random fold requests, verdict. Depends on the ALU, cwia_pkg, cwia_checker.
`timescale 1ns / 100ps
module checked_width_integer_alu_test;
  import cwia_pkg::*;

  localparam int RANDOM_BEATS = 1800;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_op;
  logic        in_wrap_mode;
  logic        in_is_signed;
  logic [6:0]  in_width;
  logic [63:0] in_operand_a;
  logic [63:0] in_operand_b;
  logic        out_valid;
  logic        out_ready;
  logic        out_folded;
  logic [63:0] out_value;
  int          fail_count;
  int          pending_folds;
  int          idle_cycles;
  bit          quiet_phase;

  checked_width_integer_alu dut (.*);

  cwia_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stall bursts, none in the quiet phase.
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
    end
  end

  // Drive one beat and hold it until accepted.
  task automatic send_fold(op_t op, logic wrap, logic sgn, logic [6:0] sz,
                           logic [63:0] a, logic [63:0] b);
    in_valid <= 1'b1;
    in_op <= op;
    in_wrap_mode <= wrap;
    in_is_signed <= sgn;
    in_width <= sz;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 9);
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'($signed($urandom_range(0, 20)) - 10);
      3: return {$urandom, $urandom};
      4: return 64'($urandom_range(0, 70));
      5: return {32'd0, $urandom} >> $urandom_range(0, 31);
      6: return -({32'd0, $urandom});
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  initial begin
    logic [6:0] sz;
    in_valid = 1'b0;
    in_op = '0;
    in_wrap_mode = 1'b0;
    in_is_signed = 1'b0;
    in_width = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    quiet_phase = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every op, extremes, bad widths, negatives, long shifts.
    send_fold(OP_ABS, 1'b0, 1'b1, 7'd64, 64'h8000_0000_0000_0000, 64'd0);
    send_fold(OP_AND, 1'b0, 1'b1, 7'd8, -64'd1, 64'd3);
    send_fold(OP_CHV, 1'b1, 1'b0, 7'd8, -64'd1, 64'd0);
    send_fold(OP_DIV, 1'b0, 1'b0, 7'd64, 64'd100, 64'd0);
    send_fold(OP_DIV, 1'b0, 1'b1, 7'd64, -64'd100, 64'd7);
    send_fold(OP_MAX, 1'b0, 1'b1, 7'd64, -64'd5, 64'd3);
    send_fold(OP_MIN, 1'b0, 1'b1, 7'd64, -64'd5, 64'd3);
    send_fold(OP_MINUS, 1'b0, 1'b1, 7'd64, 64'h8000_0000_0000_0000, 64'd1);
    send_fold(OP_MULT, 1'b1, 1'b0, 7'd64, 64'hffff_ffff_ffff, 64'hffff_ffff_ffff);
    send_fold(OP_MULT, 1'b0, 1'b1, 7'd64, 64'h8000_0000_0000_0000, -64'd1);
    send_fold(OP_NEG, 1'b0, 1'b1, 7'd1, -64'd1, 64'd0);
    send_fold(OP_NOT, 1'b1, 1'b0, 7'd64, 64'd0, 64'd0);
    send_fold(OP_NOT, 1'b0, 1'b0, 7'd8, 64'd0, 64'd0);
    send_fold(OP_OR, 1'b0, 1'b0, 7'd64, 64'h7fff_ffff_ffff_ffff, 64'd0);
    send_fold(OP_PLUS, 1'b0, 1'b1, 7'd64, 64'h7fff_ffff_ffff_ffff, 64'd1);
    send_fold(OP_PLUS, 1'b1, 1'b0, 7'd8, 64'd255, 64'd1);
    send_fold(OP_REM, 1'b0, 1'b0, 7'd64, 64'd100, 64'd7);
    send_fold(OP_SHL, 1'b1, 1'b0, 7'd64, 64'd1, 64'd63);
    send_fold(OP_SHL, 1'b1, 1'b0, 7'd64, 64'd1, 64'd64);
    send_fold(OP_SHR, 1'b1, 1'b0, 7'd64, -64'd1, 64'd200);
    send_fold(OP_XOR, 1'b0, 1'b0, 7'd64, 64'h7fff_ffff_ffff_ffff,
              64'h5555_5555_5555_5555);
    send_fold(OP_PLUS, 1'b0, 1'b0, 7'd0, 64'd1, 64'd1);
    send_fold(OP_PLUS, 1'b0, 1'b0, 7'd65, 64'd1, 64'd1);
    send_fold(OP_PLUS, 1'b0, 1'b0, 7'd127, -64'd1, -64'd1);

    // Pause until every expected result has come.
    in_valid <= 1'b0;
    @(posedge clk iff pending_folds == 0);

    // Random beats; the last stretch runs without idling.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS - 200) quiet_phase = 1'b1;
      sender_gap();
      case ($urandom_range(0, 9))
        0: sz = 7'($urandom_range(0, 127));
        1: sz = 7'd64;
        2: sz = 7'd1;
        default: sz = 7'($urandom_range(1, 64));
      endcase
      send_fold(op_t'($urandom_range(0, 15)), 1'($urandom), 1'($urandom), sz,
                pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;

    // Drain, then allow for the pipeline latency.
    @(posedge clk iff pending_folds == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_folds == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/cwia_pkg.sv
hw/rtl/cwia_divider.sv
hw/rtl/checked_width_integer_alu.sv
sim/cwia_checker.sv
sim/checked_width_integer_alu_test.sv
